/* src/ffe_pkg.sv */
package ffe_pkg;

   localparam int FlowEntries    = 64;
   localparam int EntryBits      = $clog2(FlowEntries);
   localparam int PacketsPerFlow = 3;
   localparam int CountBits      = $clog2(PacketsPerFlow + 1);

   localparam logic [10:0] LenClamp = 11'd1514;
   localparam logic [10:0] LenMin   = 11'd64;
   localparam logic [30:0] GapMax   = 31'h7FFF_FFFF;
   localparam logic [47:0] TimeoutReset = 48'd5000000000;

   localparam logic ReqPacket = 1'b0;
   localparam logic ReqAge    = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      logic        has_ports;
      logic [15:0] pkt_len;
      logic [63:0] arrival_us;
      logic [47:0] now_ticks;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [31:0] flow_lo_ip;
      logic [31:0] flow_hi_ip;
      logic [15:0] flow_lo_port;
      logic [15:0] flow_hi_port;
      logic [7:0]  flow_proto;
      logic [10:0] max_len;
      logic [30:0] max_gap_us;
      logic [1:0]  packets_counted;
      logic        aged_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] lo_ip;
      logic [31:0] hi_ip;
      logic [15:0] lo_port;
      logic [15:0] hi_port;
      logic [7:0]  proto;
   } key_type;

   // classified command handed from front to back
   typedef struct packed {
      logic        is_age;
      key_type     key;
      logic [10:0] len;
      logic        len_ok;
      logic [63:0] arrival;
      logic [47:0] now;
      logic [5:0]  index;
   } cmd_type;

endpackage

/* src/ffe_front.sv */
module ffe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ffe_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ffe_pkg::cmd_type cmd_data
);

   // two-entry command queue
   ffe_pkg::cmd_type q_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   ffe_pkg::cmd_type c;
   logic             swap, keep, do_push, do_pop;

   // canonical ordering and length classification
   always_comb begin
      swap = !((req_data.src_ip < req_data.dst_ip) ||
               (req_data.src_ip == req_data.dst_ip && req_data.sport < req_data.dport));
      c.is_age      = (req_data.req_type == ffe_pkg::ReqAge);
      c.key.lo_ip   = swap ? req_data.dst_ip : req_data.src_ip;
      c.key.hi_ip   = swap ? req_data.src_ip : req_data.dst_ip;
      c.key.lo_port = swap ? req_data.dport : req_data.sport;
      c.key.hi_port = swap ? req_data.sport : req_data.dport;
      c.key.proto   = req_data.proto;
      c.len = (req_data.pkt_len > {5'd0, ffe_pkg::LenClamp}) ? ffe_pkg::LenClamp
                                                             : req_data.pkt_len[10:0];
      c.len_ok  = (c.len >= ffe_pkg::LenMin);
      c.arrival = req_data.arrival_us;
      c.now     = req_data.now_ticks;
      c.index   = req_data.entry_index;
      keep = c.is_age || req_data.has_ports;
   end

   assign full      = (cnt_ff == 2'd2);
   assign do_push   = push && !full && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign do_pop    = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) q_ff[wp_ff] <= c;
   end

endmodule

/* src/ffe_back.sv */
module ffe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ffe_pkg::cmd_type  cmd_data,
   input  logic [47:0]       idle_timeout,
   output logic              empty,
   input  logic              pop,
   output ffe_pkg::rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   localparam int N  = ffe_pkg::FlowEntries;
   localparam int EB = ffe_pkg::EntryBits;
   localparam int CB = ffe_pkg::CountBits;

   state_type state_ff, state_in;
   ffe_pkg::cmd_type cmd_ff;

   // valid bits and keys in flops (associative match); rest in memory
   logic [N-1:0]     valid_ff, valid_in;
   ffe_pkg::key_type key_ff [N];

   logic [CB-1:0] cnt_mem  [N];
   logic [10:0]   mlen_mem [N];
   logic [30:0]   mgap_mem [N];
   logic [63:0]   prev_mem [N];
   logic [47:0]   seen_mem [N];

   logic [CB-1:0] rd_cnt;
   logic [10:0]   rd_mlen;
   logic [30:0]   rd_mgap;
   logic [63:0]   rd_prev;
   logic [47:0]   rd_seen;
   ffe_pkg::key_type rd_key;

   logic [EB-1:0] ent_ff;
   logic          hit_ff, new_ff, found_ff;

   logic [EB-1:0] hit_idx, free_idx, rd_addr;
   logic          hit_any, free_any;

   // priority search: lowest matching and lowest free entries
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == cmd_ff.key) begin
            hit_any = 1'b1;
            hit_idx = EB'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = EB'(i);
         end
      end
   end

   // entry read in the search step
   assign rd_addr = cmd_ff.is_age ? cmd_ff.index[EB-1:0] : (hit_any ? hit_idx : free_idx);

   // output register
   ffe_pkg::rsp_type out_ff, out_in;
   logic             out_v_ff, out_v_in;
   assign empty    = !out_v_ff;
   assign rsp_data = out_ff;
   assign cmd_ready = (state_ff == ST_IDLE);

   // execute stage math
   logic [CB-1:0] eff_cnt, new_cnt;
   logic [10:0]   eff_mlen, new_mlen;
   logic [30:0]   eff_mgap, new_mgap, gap;
   logic [63:0]   eff_prev, diff;
   logic          counts, emit_pkt, emit_age;
   logic [47:0]   idle;

   always_comb begin
      eff_cnt  = new_ff ? '0 : rd_cnt;
      eff_mlen = new_ff ? '0 : rd_mlen;
      eff_mgap = new_ff ? '0 : rd_mgap;
      eff_prev = new_ff ? '0 : rd_prev;
      diff = cmd_ff.arrival - eff_prev;
      if (cmd_ff.arrival < eff_prev)      gap = '0;
      else if (diff > {33'd0, ffe_pkg::GapMax}) gap = ffe_pkg::GapMax;
      else                                gap = diff[30:0];
      counts = found_ff && (eff_cnt < CB'(ffe_pkg::PacketsPerFlow)) && cmd_ff.len_ok;
      if (eff_cnt == '0) begin
         new_mlen = cmd_ff.len;
         new_mgap = '0;
      end else begin
         new_mlen = (cmd_ff.len > eff_mlen) ? cmd_ff.len : eff_mlen;
         new_mgap = (gap > eff_mgap) ? gap : eff_mgap;
      end
      new_cnt  = eff_cnt + CB'(1);
      emit_pkt = counts && (new_cnt == CB'(ffe_pkg::PacketsPerFlow));
      idle     = cmd_ff.now - rd_seen;
      emit_age = hit_ff && (idle > idle_timeout);
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      out_v_in = out_v_ff && !pop;
      out_in   = out_ff;
      case (state_ff)
         ST_IDLE: if (cmd_valid) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff.is_age) begin
               if (emit_age) state_in = ST_WAIT;
               else          state_in = ST_IDLE;
            end else begin
               if (found_ff && new_ff) valid_in[ent_ff] = 1'b1;
               if (emit_pkt) state_in = ST_WAIT;
               else          state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (!out_v_ff || pop) begin
               valid_in[ent_ff] = 1'b0;
               out_v_in = 1'b1;
               out_in.flow_lo_ip   = rd_key.lo_ip;
               out_in.flow_hi_ip   = rd_key.hi_ip;
               out_in.flow_lo_port = rd_key.lo_port;
               out_in.flow_hi_port = rd_key.hi_port;
               out_in.flow_proto   = rd_key.proto;
               out_in.max_len      = rd_mlen;
               out_in.max_gap_us   = rd_mgap;
               out_in.packets_counted = rd_cnt[1:0];
               out_in.aged_out     = cmd_ff.is_age;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
      if (state_ff == ST_IDLE && cmd_valid) cmd_ff <= cmd_data;
      // resolve the entry
      if (state_ff == ST_READ) begin
         if (cmd_ff.is_age) begin
            ent_ff   <= cmd_ff.index[EB-1:0];
            hit_ff   <= valid_ff[cmd_ff.index[EB-1:0]];
            new_ff   <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            ent_ff   <= hit_any ? hit_idx : free_idx;
            hit_ff   <= hit_any;
            new_ff   <= !hit_any;
            found_ff <= hit_any || free_any;
         end
      end
      // registered reads of the entry memories
      if (state_ff == ST_READ) begin
         rd_cnt  <= cnt_mem[rd_addr];
         rd_mlen <= mlen_mem[rd_addr];
         rd_mgap <= mgap_mem[rd_addr];
         rd_prev <= prev_mem[rd_addr];
         rd_seen <= seen_mem[rd_addr];
         rd_key  <= key_ff[rd_addr];
      end
      // updated packet features feed the emit step
      if (state_ff == ST_EXEC && !cmd_ff.is_age) begin
         rd_cnt  <= new_cnt;
         rd_mlen <= new_mlen;
         rd_mgap <= new_mgap;
         rd_key  <= cmd_ff.key;
      end
      // write back the entry
      if (state_ff == ST_EXEC && !cmd_ff.is_age && found_ff) begin
         seen_mem[ent_ff] <= cmd_ff.now;
         if (new_ff) key_ff[ent_ff] <= cmd_ff.key;
         if (counts) begin
            cnt_mem[ent_ff]  <= new_cnt;
            mlen_mem[ent_ff] <= new_mlen;
            mgap_mem[ent_ff] <= new_mgap;
            prev_mem[ent_ff] <= cmd_ff.arrival;
         end else if (new_ff) begin
            cnt_mem[ent_ff]  <= '0;
            mlen_mem[ent_ff] <= '0;
            mgap_mem[ent_ff] <= '0;
            prev_mem[ent_ff] <= '0;
         end
      end
   end

endmodule

/* src/flow_feature_extractor_core.sv */
// Bidirectional five-tuple flow table with idle aging.
// Request channel (req_*): push a transaction while full is low. A packet
// transaction is keyed on its canonical five-tuple and updates one of 64
// flow entries; an age transaction tests one entry against idle_timeout.
// Response channel (rsp_*): while empty is low the oldest feature record is
// on rsp_data; pop takes it. At most one record per request transaction.
// csr_wr_en / csr_wr_data write idle_timeout; write only while idle.
// Flow: a transaction enters a two-deep command queue in the front; the
// back takes it in its idle state, searches and reads the entry in the read
// state and updates a packet's entry in the execute state, then loads the
// response register in the wait state when a record is emitted. The back
// finishes one transaction before it takes the next, as set by the
// associative search and the single-entry memory port.
// If the response register is still full, the back holds in its emit step
// and the command queue fills, raising full.
// Reset (synchronous) frees all entries and restores idle_timeout.
module flow_feature_extractor_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ffe_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ffe_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [47:0]      csr_wr_data
);

   logic             cmd_valid, cmd_ready;
   ffe_pkg::cmd_type cmd_data;
   logic [47:0]      timeout_ff;

   // idle timeout register
   always_ff @(posedge clock) begin
      if (reset)          timeout_ff <= ffe_pkg::TimeoutReset;
      else if (csr_wr_en) timeout_ff <= csr_wr_data;
   end

   ffe_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   ffe_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .idle_timeout(timeout_ff), .empty, .pop, .rsp_data
   );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int IdleLimit = 12000;
   localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   ffe_pkg::req_type req_data;
   logic             empty;
   logic             pop;
   ffe_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [47:0]      csr_wr_data;

   flow_feature_extractor_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // flow table mirror
   logic [47:0]      timeout_mirror;
   bit               tbl_valid [ffe_pkg::FlowEntries];
   ffe_pkg::key_type tbl_key [ffe_pkg::FlowEntries];
   int               tbl_count [ffe_pkg::FlowEntries];
   logic [10:0]      tbl_max_len [ffe_pkg::FlowEntries];
   logic [30:0]      tbl_max_gap [ffe_pkg::FlowEntries];
   logic [63:0]      tbl_prev_arr [ffe_pkg::FlowEntries];
   logic [47:0]      tbl_last_seen [ffe_pkg::FlowEntries];

   ffe_pkg::rsp_type pending_features[$];
   int      mismatches = 0;
   int      records_seen = 0;
   int      items_sent = 0;
   int      idle_cycles = 0;
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;
   int      hold_off = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void emit_entry(input int e, input bit aged,
                                      output ffe_pkg::rsp_type o);
      o.flow_lo_ip      = tbl_key[e].lo_ip;
      o.flow_hi_ip      = tbl_key[e].hi_ip;
      o.flow_lo_port    = tbl_key[e].lo_port;
      o.flow_hi_port    = tbl_key[e].hi_port;
      o.flow_proto      = tbl_key[e].proto;
      o.max_len         = tbl_max_len[e];
      o.max_gap_us      = tbl_max_gap[e];
      o.packets_counted = tbl_count[e][1:0];
      o.aged_out        = aged;
      tbl_valid[e] = 1'b0;
   endfunction

   // predict the feature record (if any) caused by one transaction
   function automatic bit predict_features(input ffe_pkg::req_type r,
                                           output ffe_pkg::rsp_type o);
      ffe_pkg::key_type k;
      int          hit;
      int          fr;
      logic [15:0] len;
      logic [63:0] d;
      logic [30:0] gap;
      o = '0;
      if (r.req_type == ffe_pkg::ReqAge) begin
         if (!tbl_valid[r.entry_index]) return 1'b0;
         if (((r.now_ticks - tbl_last_seen[r.entry_index]) & Mask48) > timeout_mirror) begin
            emit_entry(r.entry_index, 1'b1, o);
            return 1'b1;
         end
         return 1'b0;
      end
      if (!r.has_ports) return 1'b0;
      if (r.src_ip < r.dst_ip || (r.src_ip == r.dst_ip && r.sport < r.dport)) begin
         k.lo_ip = r.src_ip; k.hi_ip = r.dst_ip;
         k.lo_port = r.sport; k.hi_port = r.dport;
      end else begin
         k.lo_ip = r.dst_ip; k.hi_ip = r.src_ip;
         k.lo_port = r.dport; k.hi_port = r.sport;
      end
      k.proto = r.proto;
      hit = -1;
      fr = -1;
      for (int e = 0; e < ffe_pkg::FlowEntries; e++) begin
         if (tbl_valid[e]) begin
            if (hit < 0 && tbl_key[e] == k) hit = e;
         end else if (fr < 0) begin
            fr = e;
         end
      end
      if (hit < 0) begin
         if (fr < 0) return 1'b0;
         hit = fr;
         tbl_valid[hit] = 1'b1;
         tbl_key[hit] = k;
         tbl_count[hit] = 0;
         tbl_max_len[hit] = '0;
         tbl_max_gap[hit] = '0;
         tbl_prev_arr[hit] = '0;
      end
      tbl_last_seen[hit] = r.now_ticks;
      if (tbl_count[hit] >= ffe_pkg::PacketsPerFlow) return 1'b0;
      len = (r.pkt_len > 16'd1514) ? 16'd1514 : r.pkt_len;
      if (len < 16'd64) return 1'b0;
      if (tbl_count[hit] == 0) begin
         tbl_max_len[hit] = len[10:0];
         tbl_max_gap[hit] = '0;
      end else begin
         gap = '0;
         if (len[10:0] > tbl_max_len[hit]) tbl_max_len[hit] = len[10:0];
         if (r.arrival_us >= tbl_prev_arr[hit]) begin
            d = r.arrival_us - tbl_prev_arr[hit];
            gap = (d > 64'(ffe_pkg::GapMax)) ? ffe_pkg::GapMax : d[30:0];
         end
         if (gap > tbl_max_gap[hit]) tbl_max_gap[hit] = gap;
      end
      tbl_prev_arr[hit] = r.arrival_us;
      tbl_count[hit]++;
      if (tbl_count[hit] == ffe_pkg::PacketsPerFlow) begin
         emit_entry(hit, 1'b0, o);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // push one request transaction, then idle at random
   task automatic send_req(input ffe_pkg::req_type r, input bit typed,
                           input ffe_pkg::rsp_type typed_rsp);
      ffe_pkg::rsp_type p;
      bit      has;
      @(negedge clock);
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      has = predict_features(r, p);
      if (typed) pending_features.push_back(typed_rsp);
      else if (has) pending_features.push_back(p);
      items_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
      end
   endtask

   // wait until idle, then write the timeout register
   task automatic write_timeout(input logic [47:0] v);
      @(negedge clock);
      push <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      timeout_mirror = v;
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         pop <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      ffe_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         records_seen++;
         if (pending_features.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected record %h", rsp_data);
         end else begin
            want = pending_features.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("record mismatch: expected %h, actual %h", want, rsp_data);
            end
         end
      end
   end

   // watchdog on transactions in either direction
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("flow_feature_extractor_core: mismatch");
         $finish;
      end
   end

   // random flow pool
   logic [31:0] pool_src [96];
   logic [31:0] pool_dst [96];
   logic [15:0] pool_sp [96];
   logic [15:0] pool_dp [96];
   logic [7:0]  pool_proto [96];
   int          pool_size;
   logic [63:0] arr_clock;
   logic [47:0] now_clock;

   function automatic logic [31:0] pick_ip();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0A00_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(4))
         0: return 16'h0;
         1: return 16'hFFFF;
         2: return 16'd80;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic build_pool(input int n);
      pool_size = n;
      for (int i = 0; i < n; i++) begin
         pool_src[i] = pick_ip();
         pool_dst[i] = ($urandom_range(7) == 0) ? pool_src[i] : pick_ip();
         pool_sp[i] = pick_port();
         pool_dp[i] = pick_port();
         pool_proto[i] = 8'($urandom);
      end
   endtask

   // one random transaction; returns 0 for ignored noise
   function automatic bit make_req(output ffe_pkg::req_type r);
      int k;
      int f;
      int idx;
      r = '0;
      r.req_type = ffe_pkg::ReqPacket;
      k = $urandom_range(99);
      if (k < 8) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              16'($urandom)};
         r.req_type = ffe_pkg::ReqPacket;
         r.has_ports = 1'b0;
         return 1'b0;
      end
      now_clock = now_clock + 48'($urandom_range(2000));
      if (k < 22) begin
         r.req_type = ffe_pkg::ReqAge;
         r.src_ip = $urandom;
         r.pkt_len = 16'($urandom);
         idx = $urandom_range(ffe_pkg::FlowEntries - 1);
         if ($urandom_range(1)) begin
            for (int j = 0; j < ffe_pkg::FlowEntries; j++)
               if (tbl_valid[(idx + j) % ffe_pkg::FlowEntries]) begin
                  idx = (idx + j) % ffe_pkg::FlowEntries;
                  break;
               end
         end
         r.entry_index = 6'(idx);
         case ($urandom_range(3))
            0: r.now_ticks = {16'($urandom), $urandom};
            1: r.now_ticks = now_clock;
            default: r.now_ticks = tbl_last_seen[idx] + timeout_mirror
                                   + 48'($urandom_range(2)) - 48'd1;
         endcase
         if (tbl_valid[idx] && $urandom_range(1)) begin
            r.now_ticks = tbl_last_seen[idx] + timeout_mirror + 48'($urandom_range(2)) - 48'd1;
            now_clock = r.now_ticks;
         end
         return 1'b1;
      end
      f = $urandom_range(pool_size - 1);
      r.has_ports = 1'b1;
      r.proto = pool_proto[f];
      r.entry_index = 6'($urandom);
      if ($urandom_range(1)) begin
         r.src_ip = pool_src[f]; r.dst_ip = pool_dst[f];
         r.sport = pool_sp[f]; r.dport = pool_dp[f];
      end else begin
         r.src_ip = pool_dst[f]; r.dst_ip = pool_src[f];
         r.sport = pool_dp[f]; r.dport = pool_sp[f];
      end
      case ($urandom_range(9))
         0, 1: r.pkt_len = 16'($urandom_range(63));
         2: r.pkt_len = 16'($urandom);
         3: r.pkt_len = 16'($urandom_range(65535, 1515));
         default: r.pkt_len = 16'($urandom_range(1514, 64));
      endcase
      case ($urandom_range(9))
         0: arr_clock = {$urandom, $urandom};
         1: arr_clock = arr_clock - 64'($urandom_range(5000));
         2: arr_clock = arr_clock + 64'h8000_0000 + 64'($urandom_range(3));
         default: arr_clock = arr_clock + 64'($urandom_range(100000));
      endcase
      r.arrival_us = arr_clock;
      r.now_ticks = ($urandom_range(19) == 0) ? {16'($urandom), $urandom} : now_clock;
      return 1'b1;
   endfunction

   // directed rows
   typedef struct {
      ffe_pkg::req_type r;
      bit               typed;
      ffe_pkg::rsp_type want;
   } row_type;

   row_type rows[$];

   task automatic add_row(input bit ty, input logic [31:0] sip, input logic [31:0] dip,
                          input logic [15:0] sp, input logic [15:0] dp, input logic [7:0] pr,
                          input logic hp, input logic [15:0] len, input logic [63:0] arr,
                          input logic [47:0] now, input logic [5:0] idx, input bit typed,
                          input ffe_pkg::rsp_type want);
      row_type w;
      w.r.req_type = ty;
      w.r.src_ip = sip; w.r.dst_ip = dip;
      w.r.sport = sp; w.r.dport = dp;
      w.r.proto = pr; w.r.has_ports = hp; w.r.pkt_len = len;
      w.r.arrival_us = arr; w.r.now_ticks = now; w.r.entry_index = idx;
      w.typed = typed;
      w.want = want;
      rows.push_back(w);
   endtask

   initial begin
      ffe_pkg::rsp_type none;
      ffe_pkg::rsp_type done_rec;
      ffe_pkg::rsp_type aged_rec;
      ffe_pkg::req_type r;
      logic [47:0] tmo_list [6];
      int          target;
      int          idle_list [4];
      int          stall_list [4];
      none = '0;
      push = 1'b0;
      pop = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      timeout_mirror = ffe_pkg::TimeoutReset;
      for (int e = 0; e < ffe_pkg::FlowEntries; e++) begin
         tbl_valid[e] = 1'b0;
         tbl_last_seen[e] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extreme flow: clamp, short, backward time, saturated gap
      done_rec = '{32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 8'hFF, 11'd1514,
                   31'h7FFF_FFFF, 2'd3, 1'b0};
      aged_rec = '{32'h1234_5678, 32'h1234_5678, 16'd3, 16'd9, 8'd6, 11'd0, 31'd0,
                   2'd0, 1'b1};
      add_row(ffe_pkg::ReqPacket, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 8'hFF, 0, 16'd500, 1, 1, 0,
              0, none);
      add_row(ffe_pkg::ReqPacket, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 8'hFF, 1, 16'hFFFF, 100, 10,
              0, 0, none);
      add_row(ffe_pkg::ReqPacket, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 8'hFF, 1, 16'd10, 5, 11, 0,
              0, none);
      add_row(ffe_pkg::ReqPacket, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 8'hFF, 1, 16'd64, 50, 12, 0,
              0, none);
      add_row(ffe_pkg::ReqPacket, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 8'hFF, 1, 16'd1000,
              64'hFFFF_FFFF_FFFF_FFFF, 13, 0, 1, done_rec);
      // equal addresses, short packet only, then aged with nothing counted
      add_row(ffe_pkg::ReqPacket, 32'h1234_5678, 32'h1234_5678, 9, 3, 8'd6, 1, 16'd0, 7, 100,
              0, 0, none);
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 48'd5000000101, 6'd0, 1, aged_rec);
      // age checks of free entries
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 6'd63, 0, none);
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6'd5, 0, none);
      // timeout boundary and wrap of the tick counter
      add_row(ffe_pkg::ReqPacket, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'd17, 1,
              16'd1514, 0, 0, 6'd63, 0, none);
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 48'd5000000000, 6'd0, 0, none);
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 6'd0, 0, none);
      add_row(ffe_pkg::ReqPacket, 32'h0A00_0002, 32'h0A00_0001, 16'd443, 16'd80, 8'd0, 1,
              16'd63, 10, 20, 0, 0, none);
      add_row(ffe_pkg::ReqPacket, 32'h0A00_0002, 32'h0A00_0001, 16'd443, 16'd80, 8'd0, 1,
              16'd65, 20, 30, 0, 0, none);
      add_row(ffe_pkg::ReqPacket, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'd0, 1,
              16'd1515, 9, 40, 0, 0, none);
      add_row(ffe_pkg::ReqPacket, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'd0, 1,
              16'd200, 64'h8000_0009, 50, 0, 0, none);
      add_row(ffe_pkg::ReqAge, 0, 0, 0, 0, 0, 0, 0, 0, 48'd5000000051, 6'd1, 0, none);

      sender_idle_pct = 30;
      receiver_stall_pct = 30;
      foreach (rows[i]) send_req(rows[i].r, rows[i].typed, rows[i].want);

      // random phases across timeout settings and idling patterns
      tmo_list = '{48'd0, 48'd1000, Mask48, ffe_pkg::TimeoutReset, 48'd50000,
                   48'($urandom)};
      idle_list = '{0, 88, 0, 34};
      stall_list = '{0, 0, 88, 34};
      arr_clock = 64'd1000;
      now_clock = 48'd1000;
      for (int ph = 0; ph < 8; ph++) begin
         write_timeout(tmo_list[ph % 6]);
         sender_idle_pct = idle_list[ph % 4];
         receiver_stall_pct = stall_list[ph % 4];
         build_pool((ph % 3 == 1) ? 90 : 2 + $urandom_range(10));
         if (ph == 4) begin
            sender_idle_pct = 0;
            hold_off = 2500;
         end
         target = items_sent + 192;
         while (items_sent < target) begin
            if (make_req(r)) send_req(r, 0, none);
            else begin
               send_req(r, 0, none);
               items_sent--;
            end
         end
      end

      // drain
      @(negedge clock);
      push <= 1'b0;
      receiver_stall_pct = 0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (pending_features.size() != 0) mismatches++;
      $display("run: %0d request transactions, %0d feature records checked", items_sent,
               records_seen);
      $display("covered six timeout settings, four idling patterns and a long output hold-off");
      if (mismatches == 0) begin
         $display("flow_feature_extractor_core: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("flow_feature_extractor_core: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/ffe_pkg.sv
src/ffe_front.sv
src/ffe_back.sv
src/flow_feature_extractor_core.sv
test/testbench.sv
